// ===== rtl/core/p2d_pkg.sv =====
// ----------------------------------------------------------------------------
// p2d_pkg
// Shared sizes, register codes and divider request/response types for the
// two-dimensional pooling unit.
// ----------------------------------------------------------------------------
package p2d_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int MAX_KERNEL = 8;

  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);        // 1..MAX_SIDE
  localparam int POS_W      = $clog2(MAX_SIDE);            // 0..MAX_SIDE-1
  localparam int ADDR_W     = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + $clog2(MAX_KERNEL * MAX_KERNEL);
  localparam int DIV_W      = SUM_W;
  localparam int DVSR_W     = 7;                           // kernel squared or stride
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_KERNEL = 3'd1,
    CFG_STRIDE = 3'd2,
    CFG_PAD    = 3'd3,
    CFG_HEIGHT = 3'd4,
    CFG_WIDTH  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/p2d_plane_ram.sv =====
// ----------------------------------------------------------------------------
// p2d_plane_ram
// Simple dual-port sample store: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module p2d_plane_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/p2d_divider.sv =====
// ----------------------------------------------------------------------------
// p2d_divider
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Shared between output-grid sizing and the average.
// ----------------------------------------------------------------------------
module p2d_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  p2d_pkg::div_req_t   req,
  output p2d_pkg::div_rsp_t   rsp
);

  import p2d_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic              run_r,  run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic [DIV_W-1:0]  quo_r,  quo_nxt;
  logic [DVSR_W-1:0] rem_r,  rem_nxt;
  logic [DVSR_W-1:0] dsr_r,  dsr_nxt;

  logic [DVSR_W:0]   trial;
  logic [DVSR_W:0]   diff;
  logic              ge;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    diff     = trial - {1'b0, dsr_r};
    ge       = (trial >= {1'b0, dsr_r});
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(DIV_W);
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dsr_nxt = req.divisor;
    end else if (run_r) begin
      rem_nxt = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== rtl/core/pool2d_max_avg_unit.sv =====
// ----------------------------------------------------------------------------
// pool2d_max_avg_unit
// Load item: stored at the accepting edge, busy stays low, one item a cycle.
// Request item: busy while the clipped window cells are read (up to 64, one
//   store read each through the single read port), plus a divide in average
//   mode; an empty window is not scanned. The result strobe comes in the
//   same cycle that busy falls; the receiver cannot stall it. After any
//   register write the first request also sizes the grid on the divider.
// Reset (synchronous, rst_n low): registers to defaults, pointers to zero,
//   sequencer idle; the sample store is not cleared.
// ----------------------------------------------------------------------------
module pool2d_max_avg_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_action,
  input  logic signed [15:0]                in_sample,
  // result channel
  output logic                              out_strobe,
  output logic signed [15:0]                out_pooled,
  output logic [11:0]                       out_winner_index,
  output logic                              out_final_flag,
  // configuration
  input  logic                              cfg_we,
  input  logic [p2d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [p2d_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import p2d_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIMH_GO,
    ST_DIMH_WAIT,
    ST_DIMW_GO,
    ST_DIMW_WAIT,
    ST_POS,
    ST_WIN,
    ST_SCAN,
    ST_DRAIN,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_DONE
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        mode_r;
  logic [3:0]  kernel_r;
  logic [3:0]  stride_r;
  logic [2:0]  pad_r;
  logic [6:0]  height_r;
  logic [6:0]  width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      kernel_r <= 4'd2;
      stride_r <= 4'd2;
      pad_r    <= 3'd0;
      height_r <= 7'(MAX_SIDE);
      width_r  <= 7'(MAX_SIDE);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_KERNEL: kernel_r <= cfg_data[3:0];
        CFG_STRIDE: stride_r <= cfg_data[3:0];
        CFG_PAD:    pad_r    <= cfg_data[2:0];
        CFG_HEIGHT: height_r <= cfg_data[6:0];
        CFG_WIDTH:  width_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Effective values: out-of-range codes are folded back into range.
  logic [SIDE_W-1:0] h_eff, w_eff;
  logic [3:0]        k_eff, s_eff;

  always_comb begin
    if (height_r == '0)                 h_eff = SIDE_W'(1);
    else if (height_r > 7'(MAX_SIDE))   h_eff = SIDE_W'(MAX_SIDE);
    else                                h_eff = height_r;
    if (width_r == '0)                  w_eff = SIDE_W'(1);
    else if (width_r > 7'(MAX_SIDE))    w_eff = SIDE_W'(MAX_SIDE);
    else                                w_eff = width_r;
    if (kernel_r == '0)                 k_eff = 4'd1;
    else if (kernel_r > 4'(MAX_KERNEL)) k_eff = 4'(MAX_KERNEL);
    else                                k_eff = kernel_r;
    s_eff = (stride_r == '0) ? 4'd1 : stride_r;
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_t            state_r,    state_nxt;
  logic              dims_ok_r,  dims_ok_nxt;
  logic [SIDE_W-1:0] oh_r,       oh_nxt;
  logic [SIDE_W-1:0] ow_r,       ow_nxt;
  logic [ADDR_W-1:0] lp_r,       lp_nxt;
  logic [POS_W-1:0]  out_row_r,  out_row_nxt;
  logic [POS_W-1:0]  out_col_r,  out_col_nxt;

  logic [POS_W-1:0]  r_lo_r,     r_lo_nxt;
  logic [SIDE_W-1:0] r_hi_r,     r_hi_nxt;
  logic [SIDE_W-1:0] c_hi_r,     c_hi_nxt;
  logic [POS_W-1:0]  scan_row_r, scan_row_nxt;
  logic [POS_W-1:0]  scan_col_r, scan_col_nxt;

  logic              pend_r,     pend_nxt;
  logic [ADDR_W-1:0] pend_idx_r, pend_idx_nxt;
  logic              have_r,     have_nxt;
  logic signed [SAMPLE_W-1:0] best_r, best_nxt;
  logic [ADDR_W-1:0] win_r,      win_nxt;
  logic signed [SUM_W-1:0]    sum_r,  sum_nxt;

  logic              strobe_r,   strobe_nxt;
  logic signed [SAMPLE_W-1:0] pooled_r, pooled_nxt;
  logic [ADDR_W-1:0] winner_r,   winner_nxt;
  logic              final_r,    final_nxt;

  // --------------------------------------------------------------------------
  // Sample store
  // --------------------------------------------------------------------------
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [SAMPLE_W-1:0]  ram_rdata;

  p2d_plane_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_sample),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  div_req_t div_req;
  div_rsp_t div_rsp;

  p2d_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic                accept;
  logic [2*SIDE_W-1:0] total_full;
  logic [ADDR_W:0]     total;
  logic [ADDR_W-1:0]   lp_eff;
  logic [ADDR_W:0]     lp_inc;

  // grid sizing: (side + 2*pad - kernel) / stride + 1
  logic [SIDE_W-1:0]   dim_side;
  logic signed [9:0]   dim_num;
  logic                dim_neg;
  logic [SIDE_W-1:0]   dim_qp1;
  logic [SIDE_W-1:0]   dim_val;
  logic [7:0]          kk_full;

  // window bounds
  logic [9:0]          row_off, col_off;
  logic signed [11:0]  r0s, c0s, r1s, c1s, r0c, c0c, r1c, c1c;
  logic                win_empty;

  // scan
  logic [2*ADDR_W+1:0] addr_full;
  logic                row_end, col_end;

  // average
  logic                sum_neg;
  logic [SUM_W-1:0]    sum_mag;
  logic [SAMPLE_W-1:0] q16;

  logic                at_last;
  logic                avg_phase;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // load pointer wraps at the plane size, which may have shrunk since
  assign total_full = {{SIDE_W{1'b0}}, h_eff} * {{SIDE_W{1'b0}}, w_eff};
  assign total      = total_full[ADDR_W:0];
  assign lp_eff     = ({1'b0, lp_r} >= total) ? '0 : lp_r;
  assign lp_inc     = {1'b0, lp_eff} + (ADDR_W+1)'(1);

  assign ram_we     = accept && !in_action;
  assign ram_waddr  = lp_eff;

  assign dim_side = (state_r == ST_DIMH_GO || state_r == ST_DIMH_WAIT) ? h_eff : w_eff;
  assign dim_num  = $signed({3'b0, dim_side}) + $signed({6'b0, pad_r, 1'b0})
                  - $signed({6'b0, k_eff});
  assign dim_neg  = dim_num[9];
  assign dim_qp1  = div_rsp.quotient[SIDE_W-1:0] + SIDE_W'(1);
  assign dim_val  = dim_neg ? SIDE_W'(1) :
                    (dim_qp1 > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : dim_qp1;
  assign kk_full  = {4'b0, k_eff} * {4'b0, k_eff};

  assign sum_neg  = sum_r[SUM_W-1];
  assign sum_mag  = sum_neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign q16      = div_rsp.quotient[SAMPLE_W-1:0];

  assign avg_phase = (state_r == ST_AVG_GO || state_r == ST_AVG_WAIT);

  always_comb begin
    div_req.start    = (state_r == ST_DIMH_GO) || (state_r == ST_DIMW_GO)
                     || (state_r == ST_AVG_GO);
    div_req.dividend = avg_phase ? sum_mag :
                       (dim_neg ? '0 : {{(DIV_W-9){1'b0}}, dim_num[8:0]});
    div_req.divisor  = avg_phase ? kk_full[DVSR_W-1:0] : {3'b0, s_eff};
  end

  // window: starts at pos*stride - pad, clipped to the plane
  assign row_off = {4'b0, out_row_r} * {6'b0, s_eff};
  assign col_off = {4'b0, out_col_r} * {6'b0, s_eff};
  assign r0s     = $signed({2'b0, row_off}) - $signed({9'b0, pad_r});
  assign c0s     = $signed({2'b0, col_off}) - $signed({9'b0, pad_r});
  assign r1s     = r0s + $signed({8'b0, k_eff});
  assign c1s     = c0s + $signed({8'b0, k_eff});
  assign r1c     = (r1s > $signed({5'b0, h_eff})) ? $signed({5'b0, h_eff}) : r1s;
  assign c1c     = (c1s > $signed({5'b0, w_eff})) ? $signed({5'b0, w_eff}) : c1s;
  assign r0c     = r0s[11] ? '0 : r0s;
  assign c0c     = c0s[11] ? '0 : c0s;
  assign win_empty = (r0c >= r1c) || (c0c >= c1c);

  // column-major walk: rows inside, columns outside
  assign addr_full = {{(ADDR_W-POS_W+2){1'b0}}, scan_row_r}
                   * {{(ADDR_W-SIDE_W+2){1'b0}}, w_eff}
                   + {{(ADDR_W-POS_W+2){1'b0}}, scan_col_r};
  assign ram_raddr = addr_full[ADDR_W-1:0];
  assign row_end   = (({1'b0, scan_row_r}) + SIDE_W'(1)) == r_hi_r;
  assign col_end   = (({1'b0, scan_col_r}) + SIDE_W'(1)) == c_hi_r;

  assign at_last = ({1'b0, out_row_r} == oh_r - SIDE_W'(1))
                && ({1'b0, out_col_r} == ow_r - SIDE_W'(1));

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    dims_ok_nxt  = dims_ok_r;
    oh_nxt       = oh_r;
    ow_nxt       = ow_r;
    lp_nxt       = lp_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    r_lo_nxt     = r_lo_r;
    r_hi_nxt     = r_hi_r;
    c_hi_nxt     = c_hi_r;
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    have_nxt     = have_r;
    best_nxt     = best_r;
    win_nxt      = win_r;
    sum_nxt      = sum_r;
    strobe_nxt   = 1'b0;
    pooled_nxt   = pooled_r;
    winner_nxt   = winner_r;
    final_nxt    = final_r;

    // fold in the sample read issued last cycle
    if (pend_r) begin
      if (!mode_r) begin
        if (!have_r || ($signed(ram_rdata) > best_r)) begin
          have_nxt = 1'b1;
          best_nxt = $signed(ram_rdata);
          win_nxt  = pend_idx_r;
        end
      end else begin
        sum_nxt = sum_r + SUM_W'($signed(ram_rdata));
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_action) begin
            if (lp_eff == '0) begin
              out_row_nxt = '0;
              out_col_nxt = '0;
            end
            lp_nxt = (lp_inc >= total) ? '0 : lp_inc[ADDR_W-1:0];
          end else begin
            state_nxt = dims_ok_r ? ST_POS : ST_DIMH_GO;
          end
        end
      end
      ST_DIMH_GO:   state_nxt = ST_DIMH_WAIT;
      ST_DIMH_WAIT: begin
        if (div_rsp.done) begin
          oh_nxt    = dim_val;
          state_nxt = ST_DIMW_GO;
        end
      end
      ST_DIMW_GO:   state_nxt = ST_DIMW_WAIT;
      ST_DIMW_WAIT: begin
        if (div_rsp.done) begin
          ow_nxt      = dim_val;
          dims_ok_nxt = 1'b1;
          state_nxt   = ST_POS;
        end
      end
      ST_POS: begin
        // a register change may have shrunk the grid under the position
        if (({1'b0, out_row_r} >= oh_r) || ({1'b0, out_col_r} >= ow_r)) begin
          out_row_nxt = '0;
          out_col_nxt = '0;
        end
        state_nxt = ST_WIN;
      end
      ST_WIN: begin
        have_nxt     = 1'b0;
        best_nxt     = '0;
        win_nxt      = '0;
        sum_nxt      = '0;
        r_lo_nxt     = r0c[POS_W-1:0];
        r_hi_nxt     = r1c[SIDE_W-1:0];
        c_hi_nxt     = c1c[SIDE_W-1:0];
        scan_row_nxt = r0c[POS_W-1:0];
        scan_col_nxt = c0c[POS_W-1:0];
        state_nxt    = win_empty ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        pend_nxt     = 1'b1;
        pend_idx_nxt = ram_raddr;
        if (row_end) begin
          scan_row_nxt = r_lo_r;
          scan_col_nxt = scan_col_r + POS_W'(1);
          if (col_end) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          scan_row_nxt = scan_row_r + POS_W'(1);
        end
      end
      ST_DRAIN:  state_nxt = mode_r ? ST_AVG_GO : ST_DONE;
      ST_AVG_GO: state_nxt = ST_AVG_WAIT;
      ST_AVG_WAIT: begin
        if (div_rsp.done) begin
          // truncation toward zero: divide the magnitude, restore the sign
          best_nxt  = sum_neg ? $signed(-q16) : $signed(q16);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        strobe_nxt = 1'b1;
        pooled_nxt = best_r;
        winner_nxt = win_r;
        final_nxt  = at_last;
        if (({1'b0, out_col_r} + SIDE_W'(1)) >= ow_r) begin
          out_col_nxt = '0;
          out_row_nxt = (({1'b0, out_row_r} + SIDE_W'(1)) >= oh_r) ? '0
                      : out_row_r + POS_W'(1);
        end else begin
          out_col_nxt = out_col_r + POS_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // any register write invalidates the cached grid size
    if (cfg_we) begin
      dims_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      dims_ok_r <= 1'b0;
      lp_r      <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      pend_r    <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dims_ok_r <= dims_ok_nxt;
      lp_r      <= lp_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      pend_r    <= pend_nxt;
      strobe_r  <= strobe_nxt;
    end
    oh_r       <= oh_nxt;
    ow_r       <= ow_nxt;
    r_lo_r     <= r_lo_nxt;
    r_hi_r     <= r_hi_nxt;
    c_hi_r     <= c_hi_nxt;
    scan_row_r <= scan_row_nxt;
    scan_col_r <= scan_col_nxt;
    pend_idx_r <= pend_idx_nxt;
    have_r     <= have_nxt;
    best_r     <= best_nxt;
    win_r      <= win_nxt;
    sum_r      <= sum_nxt;
    pooled_r   <= pooled_nxt;
    winner_r   <= winner_nxt;
    final_r    <= final_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_pooled       = pooled_r;
  assign out_winner_index = winner_r;
  assign out_final_flag   = final_r;

endmodule

// ===== verif/pool2d_max_avg_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool2d_max_avg_unit_tb
// Self-checking bench for the 2-D max/average pooling unit. Items (sample
// loads and pooled-output requests) are queued up front and played through
// the start/busy handshake with random gaps. Each accepted item runs through
// a behavioural predictor of the pooling unit. Every result strobe is checked
// against the oldest predicted result, field by field.
// ----------------------------------------------------------------------------
module pool2d_max_avg_unit_tb;
  import p2d_pkg::*;

  // item codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_POOL = 1'b1;
  localparam int   MODE_MAX = 0;
  localparam int   MODE_AVG = 1;

  localparam int N_REGS         = 6;
  // worst request: average mode, a full window and grid sizing after a write
  localparam int SETTLE_CYCLES  = 200;
  localparam int TAIL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 650;
  localparam int N_CORNER       = 7;

  // register file as the unit sees it (raw, masked to register width)
  typedef struct {
    int mode;
    int kernel;
    int stride;
    int pad;
    int height;
    int width;
  } pool_cfg_t;

  // effective geometry after clamping, plus output grid size
  typedef struct {
    int h, w, k, s, p, oh, ow;
  } geom_t;

  typedef struct {
    logic signed [15:0] pooled;
    logic [11:0]        winner;
    logic               final_flag;
  } pool_result_t;

  // one queued entry: either a register write or an item
  typedef struct {
    logic                  is_cfg;
    cfg_idx_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  action;
    logic signed [15:0]    sample;
    int                    gap_pct;
  } stim_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_action = 1'b0;
  logic signed [15:0]    in_sample = '0;
  logic                  out_strobe;
  logic signed [15:0]    out_pooled;
  logic [11:0]           out_winner_index;
  logic                  out_final_flag;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pool2d_max_avg_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_sample        (in_sample),
    .out_strobe       (out_strobe),
    .out_pooled       (out_pooled),
    .out_winner_index (out_winner_index),
    .out_final_flag   (out_final_flag),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  stim_t        stim_q[$];
  pool_result_t pooled_q[$];   // predicted results, oldest first
  int           err_cnt;
  int           settle_cnt;
  int           quiet_cycles;

  // predictor state
  logic signed [15:0] plane_mem [0:MAX_SIDE*MAX_SIDE-1];
  int                 load_addr;
  int                 next_row;
  int                 next_col;
  pool_cfg_t          pred_cfg;

  // planning state: register view and how much of the store is written
  pool_cfg_t plan_cfg;
  int        loaded_span;
  int        planned_items;
  int        cur_gap;

  // --------------------------------------------------------------------------
  // Register and geometry helpers
  // --------------------------------------------------------------------------
  function automatic pool_cfg_t mk_cfg(int m, int k, int s, int p, int h, int w);
    pool_cfg_t c;
    c.mode = m; c.kernel = k; c.stride = s; c.pad = p; c.height = h; c.width = w;
    return c;
  endfunction

  function automatic pool_cfg_t with_reg(pool_cfg_t c, cfg_idx_t idx, int val);
    case (idx)
      CFG_MODE:   c.mode   = val & 1;
      CFG_KERNEL: c.kernel = val & 15;
      CFG_STRIDE: c.stride = val & 15;
      CFG_PAD:    c.pad    = val & 7;
      CFG_HEIGHT: c.height = val & 127;
      CFG_WIDTH:  c.width  = val & 127;
      default: ;
    endcase
    return c;
  endfunction

  function automatic int reg_value(pool_cfg_t c, cfg_idx_t idx);
    case (idx)
      CFG_MODE:   return c.mode;
      CFG_KERNEL: return c.kernel;
      CFG_STRIDE: return c.stride;
      CFG_PAD:    return c.pad;
      CFG_HEIGHT: return c.height;
      CFG_WIDTH:  return c.width;
      default:    return 0;
    endcase
  endfunction

  function automatic int clampv(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // outputs along one axis; one window when the kernel overhangs the padded
  // side, saturating at the largest grid the unit tracks
  function automatic int grid_dim(int side, int k, int s, int p);
    int num;
    num = side + 2 * p - k;
    if (num < 0) return 1;
    return clampv(num / s + 1, 1, MAX_SIDE);
  endfunction

  function automatic geom_t shape_of(pool_cfg_t c);
    geom_t g;
    g.h  = clampv(c.height, 1, MAX_SIDE);
    g.w  = clampv(c.width, 1, MAX_SIDE);
    g.k  = clampv(c.kernel, 1, MAX_KERNEL);
    g.s  = clampv(c.stride, 1, 15);
    g.p  = c.pad;
    g.oh = grid_dim(g.h, g.k, g.s, g.p);
    g.ow = grid_dim(g.w, g.k, g.s, g.p);
    return g;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: one accepted item in, zero or one pooled result out
  // --------------------------------------------------------------------------
  function automatic void pool_step(logic action, logic signed [15:0] sample);
    geom_t        g;
    int           total, r0, c0, r1, c1, acc, best;
    logic [11:0]  widx;
    bit           have;
    pool_result_t res;
    g = shape_of(pred_cfg);
    total = g.h * g.w;
    if (action == ACT_LOAD) begin
      // a write at address 0 opens a new plane and rewinds the output walk
      if (load_addr >= total) load_addr = 0;
      if (load_addr == 0) begin
        next_row = 0;
        next_col = 0;
      end
      plane_mem[load_addr] = sample;
      load_addr = load_addr + 1;
      if (load_addr >= total) load_addr = 0;
      return;
    end
    // position left outside a shrunken grid restarts at the origin
    if (next_row >= g.oh || next_col >= g.ow) begin
      next_row = 0;
      next_col = 0;
    end
    r0 = next_row * g.s - g.p;
    c0 = next_col * g.s - g.p;
    r1 = (r0 + g.k > g.h) ? g.h : r0 + g.k;
    c1 = (c0 + g.k > g.w) ? g.w : c0 + g.k;
    if (r0 < 0) r0 = 0;
    if (c0 < 0) c0 = 0;
    best = 0;
    acc  = 0;
    widx = '0;
    have = 1'b0;
    if (r0 < r1 && c0 < c1) begin
      if (pred_cfg.mode == MODE_MAX) begin
        // column-major scan, strict compare: first maximum keeps the win
        for (int c = c0; c < c1; c++) begin
          for (int r = r0; r < r1; r++) begin
            if (!have || plane_mem[r * g.w + c] > best) begin
              have = 1'b1;
              best = plane_mem[r * g.w + c];
              widx = 12'(r * g.w + c);
            end
          end
        end
      end else begin
        for (int r = r0; r < r1; r++) begin
          for (int c = c0; c < c1; c++) begin
            acc += plane_mem[r * g.w + c];
          end
        end
        // full kernel area as divisor even when clipped; truncates to zero
        best = acc / (g.k * g.k);
      end
    end
    res.pooled     = best[15:0];
    res.winner     = widx;
    res.final_flag = (next_row == g.oh - 1) && (next_col == g.ow - 1);
    next_col++;
    if (next_col >= g.ow) begin
      next_col = 0;
      next_row++;
      if (next_row >= g.oh) next_row = 0;
    end
    pooled_q.insert(pooled_q.size(), res);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------
  function automatic void add_cfg(cfg_idx_t idx, int val);
    stim_t e;
    e.is_cfg  = 1'b1;
    e.reg_idx = idx;
    e.reg_val = val[CFG_DATA_W-1:0];
    e.action  = ACT_LOAD;
    e.sample  = '0;
    e.gap_pct = cur_gap;
    stim_q.insert(stim_q.size(), e);
    plan_cfg = with_reg(plan_cfg, idx, val);
  endfunction

  function automatic void add_item(logic action, logic signed [15:0] value);
    stim_t e;
    e.is_cfg  = 1'b0;
    e.reg_idx = CFG_MODE;
    e.reg_val = '0;
    e.action  = action;
    e.sample  = value;
    e.gap_pct = cur_gap;
    stim_q.insert(stim_q.size(), e);
    planned_items++;
  endfunction

  // tie-heavy planes draw from a tiny value set
  function automatic logic signed [15:0] next_sample(bit ties);
    case ($urandom_range(9, 0))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: begin
        if (!ties) return 16'($urandom);
        case ($urandom_range(2, 0))
          0:       return -16'sd2;
          1:       return 16'sd0;
          default: return 16'sd3;
        endcase
      end
    endcase
  endfunction

  function automatic pool_cfg_t random_cfg();
    pool_cfg_t c;
    c = plan_cfg;
    c.mode   = $urandom_range(1, 0);
    c.kernel = ($urandom_range(9, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(8, 1);
    c.stride = ($urandom_range(9, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(8, 1);
    c.pad    = ($urandom_range(2, 0) == 0) ? $urandom_range(7, 0) : $urandom_range(2, 0);
    // half the time keep the plane, so the walk may sit outside the new grid
    if ($urandom_range(1, 0) == 1) begin
      c.height = $urandom_range(12, 1);
      c.width  = $urandom_range(12, 1);
    end
    return c;
  endfunction

  // Writes the registers that change (plus a few rewrites, or all of them
  // with write_all), reloads the plane when the current one does not cover
  // it (or at random), then queues requests with the odd stray load mixed in.
  function automatic void plan_phase(pool_cfg_t want, int n_req, bit ties, bit write_all);
    cfg_idx_t idx;
    geom_t    g;
    for (int i = 0; i < N_REGS; i++) begin
      idx = cfg_idx_t'(i);
      if (write_all || reg_value(want, idx) != reg_value(plan_cfg, idx) ||
          $urandom_range(3, 0) == 0)
        add_cfg(idx, reg_value(want, idx));
    end
    g = shape_of(plan_cfg);
    if (g.h * g.w > loaded_span || $urandom_range(4, 0) == 0) begin
      for (int i = 0; i < g.h * g.w; i++) add_item(ACT_LOAD, next_sample(ties));
      if (g.h * g.w > loaded_span) loaded_span = g.h * g.w;
    end
    for (int i = 0; i < n_req; i++) begin
      if ($urandom_range(99, 0) < 8) add_item(ACT_LOAD, next_sample(ties));
      add_item(ACT_POOL, 16'($urandom));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: plays the queue; register writes wait for a drained, quiet unit
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic  nxt_start;
    logic  nxt_we;
    stim_t head;
    if (!rst_n) begin
      start      <= 1'b0;
      cfg_we     <= 1'b0;
      settle_cnt <= 0;
      load_addr  = 0;
      next_row   = 0;
      next_col   = 0;
      pred_cfg   = mk_cfg(MODE_MAX, 2, 2, 0, 64, 64);
    end else begin
      nxt_start = start;
      nxt_we    = 1'b0;
      if (start && !busy) begin
        pool_step(in_action, in_sample);
        nxt_start = 1'b0;
      end
      // channel free unless an item is still being held off
      if (!(start && busy) && stim_q.size() != 0) begin
        head = stim_q[0];
        if (head.is_cfg) begin
          if (pooled_q.size() != 0) begin
            settle_cnt <= 0;
          end else if (settle_cnt < SETTLE_CYCLES) begin
            settle_cnt <= settle_cnt + 1;
          end else begin
            nxt_we = 1'b1;
            cfg_index <= head.reg_idx;
            cfg_data  <= head.reg_val;
            pred_cfg = with_reg(pred_cfg, head.reg_idx, head.reg_val);
            void'(stim_q.pop_front());
          end
        end else if ($urandom_range(99, 0) >= head.gap_pct) begin
          nxt_start = 1'b1;
          in_action  <= head.action;
          in_sample  <= head.sample;
          settle_cnt <= 0;
          void'(stim_q.pop_front());
        end
      end
      start  <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every strobe must match the oldest predicted result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pool_result_t want;
    if (rst_n && out_strobe) begin
      if (pooled_q.size() == 0) begin
        $error("result with none pending: pooled %0d winner %0d final %0b",
               out_pooled, out_winner_index, out_final_flag);
        err_cnt++;
      end else begin
        want = pooled_q.pop_front();
        if (out_pooled !== want.pooled) begin
          $error("pooled: expected %0d, got %0d", want.pooled, out_pooled);
          err_cnt++;
        end
        if (out_winner_index !== want.winner) begin
          $error("winner_index: expected %0d, got %0d", want.winner, out_winner_index);
          err_cnt++;
        end
        if (out_final_flag !== want.final_flag) begin
          $error("final_flag: expected %0b, got %0b", want.final_flag, out_final_flag);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: any item, result or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    pool_cfg_t corner_cfgs [N_CORNER];
    pool_cfg_t want;
    geom_t     g;
    int        base_items, done_items, phase_no, ci, n_req;

    err_cnt       = 0;
    quiet_cycles  = 0;
    loaded_span   = 0;
    planned_items = 0;
    cur_gap       = 24;
    plan_cfg      = mk_cfg(MODE_MAX, 2, 2, 0, 64, 64);

    // Directed: 2x4 plane with kernel, stride, pad and mode left at reset.
    // Left window holds the most negative values; right window has a tie
    // that column-major order settles differently from row-major.
    add_cfg(CFG_HEIGHT, 2);
    add_cfg(CFG_WIDTH, 4);
    add_item(ACT_LOAD, 16'sh8000);
    add_item(ACT_LOAD, -16'sd3);
    add_item(ACT_LOAD, 16'sd0);
    add_item(ACT_LOAD, 16'sh7fff);
    add_item(ACT_LOAD, 16'sh8000);
    add_item(ACT_LOAD, -16'sd2);
    add_item(ACT_LOAD, 16'sh7fff);
    add_item(ACT_LOAD, 16'sh7fff);
    loaded_span = 8;
    // three requests: the last wraps past the final output
    repeat (3) add_item(ACT_POOL, 16'sh0000);
    // average mode: negative sum truncates toward zero
    add_cfg(CFG_MODE, MODE_AVG);
    repeat (2) add_item(ACT_POOL, 16'shffff);

    // corner settings: kernel over the padded plane, all-padding windows,
    // saturated grid, zero and oversized register values
    corner_cfgs[0] = mk_cfg(MODE_MAX, 8, 1, 0, 1, 1);
    corner_cfgs[1] = mk_cfg(MODE_AVG, 8, 8, 7, 3, 5);
    corner_cfgs[2] = mk_cfg(MODE_MAX, 1, 1, 7, 64, 1);
    corner_cfgs[3] = mk_cfg(MODE_AVG, 2, 1, 7, 2, 2);
    corner_cfgs[4] = mk_cfg(MODE_MAX, 0, 0, 0, 5, 7);
    corner_cfgs[5] = mk_cfg(MODE_AVG, 15, 15, 3, 127, 0);
    corner_cfgs[6] = mk_cfg(MODE_MAX, 9, 2, 1, 0, 64);

    // Random phases: sender gaps 24%, then 81%, then none
    base_items = planned_items;
    phase_no   = 0;
    ci         = 0;
    while (planned_items - base_items < RANDOM_ITEMS) begin
      done_items = planned_items - base_items;
      cur_gap = (done_items < RANDOM_ITEMS / 3)     ? 24 :
                (done_items < 2 * RANDOM_ITEMS / 3) ? 81 : 0;
      if (phase_no % 3 == 1 && ci < N_CORNER) begin
        want = corner_cfgs[ci];
        ci++;
      end else begin
        want = random_cfg();
      end
      g = shape_of(want);
      // mostly whole walks so the final flag and wrap are seen
      if (g.oh * g.ow <= 40 && $urandom_range(9, 0) < 7)
        n_req = g.oh * g.ow + $urandom_range(2, 0);
      else
        n_req = $urandom_range(30, 1);
      plan_phase(want, n_req, $urandom_range(4, 0) == 0, phase_no == 0);
      phase_no++;
    end

    // tall plane once, then reused with the larger winner indexes
    cur_gap = 0;
    plan_phase(mk_cfg(MODE_AVG, 8, 8, 0, 64, 4), 64, 1'b0, 1'b0);
    plan_phase(mk_cfg(MODE_MAX, 3, 2, 1, 64, 4), 40, 1'b0, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || start || pooled_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0 && pooled_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
